>>> src/rhd_pkg.sv
// Package for the register hazard detector: shared constants, codes and types.
// Depends on nothing; every other file of the block but rhd_ram imports it.
package rhd_pkg;

    // Defaults for the top-level parameters.
    localparam int NUM_REGS_DEFAULT   = 32;
    localparam int INDEX_BITS_DEFAULT = 16;

    // Fixed field widths of the channels.
    localparam int REG_NUM_W   = 6;
    localparam int DEP_REG_W   = 5;
    localparam int OUT_INDEX_W = 16;

    // Register number that stands for no register.
    localparam logic [REG_NUM_W-1:0] REG_ABSENT = 6'd32;

    // Depth of the instruction queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Access slots of one instruction, in the order they are carried out.
    localparam int SLOT_COUNT = 3;
    localparam int SLOT_SRC_A = 0;
    localparam int SLOT_SRC_B = 1;
    localparam int SLOT_DEST  = 2;

    typedef enum logic [1:0] {
        INST_R     = 2'd0,
        INST_I     = 2'd1,
        INST_J     = 2'd2,
        INST_OTHER = 2'd3
    } inst_type_t;

    typedef enum logic [1:0] {
        DEP_RAW = 2'd0,
        DEP_WAR = 2'd1,
        DEP_WAW = 2'd2
    } dep_kind_t;

endpackage

>>> src/rhd_if.sv
// Channel interfaces of the register hazard detector: instruction in, hazard out.
// Depends on rhd_pkg for the field widths.
interface rhd_inst_if
    import rhd_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [1:0]           inst_type;
    logic [REG_NUM_W-1:0] src_a;
    logic [REG_NUM_W-1:0] src_b_or_dest;
    logic [REG_NUM_W-1:0] dest_reg;

    modport source (output valid, inst_type, src_a, src_b_or_dest, dest_reg, input ready);
    modport sink   (input valid, inst_type, src_a, src_b_or_dest, dest_reg, output ready);
endinterface

interface rhd_dep_if
    import rhd_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [1:0]             dep_kind;
    logic [DEP_REG_W-1:0]   dep_register;
    logic [OUT_INDEX_W-1:0] earlier_index;
    logic [OUT_INDEX_W-1:0] later_index;
    logic                   last_of_run;

    modport source (output valid, dep_kind, dep_register, earlier_index, later_index,
                    last_of_run, input ready);
    modport sink   (input valid, dep_kind, dep_register, earlier_index, later_index,
                    last_of_run, output ready);
endinterface

>>> src/rhd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; used for the per-register access records.
module rhd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             rd_en,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when the same address is written in that cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/rhd_queue.sv
// Small register FIFO between the front and the back of the hazard detector.
// Depends on rhd_pkg for its depth.
module rhd_queue
    import rhd_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // Status and pointer arithmetic.
    always_comb
    begin
        full       = (count_reg == CNT_W'(QUEUE_DEPTH));
        head_valid = (count_reg != '0);
        head_data  = entry_reg[rd_ptr_reg];
        do_push    = push && !full;
        do_pop     = pop && head_valid;

        wr_ptr_next = wr_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        rd_ptr_next = rd_ptr_reg;
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> src/rhd_front.sv
// Front of the hazard detector: accepts instructions, stamps their index and
// decodes them into access slots for the queue. Depends on rhd_pkg and rhd_if.
module rhd_front
    import rhd_pkg::*;
#(
    parameter int NUM_REGS   = NUM_REGS_DEFAULT,
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
    parameter int REG_W      = 5,
    parameter int ENTRY_W    = INDEX_BITS + SLOT_COUNT + SLOT_COUNT * REG_W
) (
    input  logic               clk,
    input  logic               rst_n,
    rhd_inst_if.sink           instr,
    output logic               q_push,
    output logic [ENTRY_W-1:0] q_data,
    input  logic               q_full
);

    typedef struct packed {
        logic [INDEX_BITS-1:0]                index;
        logic [SLOT_COUNT-1:0]                present;
        logic [SLOT_COUNT-1:0][REG_W-1:0]     regs;
    } entry_t;

    entry_t                entry;
    logic                  fire;
    logic                  a_ok;
    logic                  b_ok;
    logic                  d_ok;
    logic [INDEX_BITS-1:0] count_reg, count_next;

    // A register number takes part only if it is neither absent nor out of range.
    always_comb
    begin
        a_ok = (instr.src_a != REG_ABSENT) && (32'(instr.src_a) < NUM_REGS);
        b_ok = (instr.src_b_or_dest != REG_ABSENT) && (32'(instr.src_b_or_dest) < NUM_REGS);
        d_ok = (instr.dest_reg != REG_ABSENT) && (32'(instr.dest_reg) < NUM_REGS);
    end

    // Decode into the three slots: read rs, read rt, then the write.
    always_comb
    begin
        entry.index            = count_reg;
        entry.present          = '0;
        entry.regs[SLOT_SRC_A] = instr.src_a[REG_W-1:0];
        entry.regs[SLOT_SRC_B] = instr.src_b_or_dest[REG_W-1:0];
        entry.regs[SLOT_DEST]  = instr.dest_reg[REG_W-1:0];
        case (inst_type_t'(instr.inst_type))
            INST_R:
            begin
                entry.present[SLOT_SRC_A] = a_ok;
                entry.present[SLOT_SRC_B] = b_ok;
                entry.present[SLOT_DEST]  = d_ok;
            end
            INST_I:
            begin
                entry.present[SLOT_SRC_A] = a_ok;
                entry.present[SLOT_DEST]  = b_ok;
                entry.regs[SLOT_DEST]     = instr.src_b_or_dest[REG_W-1:0];
            end
            default:
            begin
                entry.present = '0;
            end
        endcase
    end

    // Handshake; instructions without any access are counted but not queued.
    always_comb
    begin
        instr.ready = !q_full;
        fire        = instr.valid && !q_full;
        q_push      = fire && (entry.present != '0);
        q_data      = entry;
        count_next  = count_reg;
        if (fire && !(&count_reg))
        begin
            count_next = count_reg + 1'b1;
        end
    end

    // Saturating instruction counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

>>> src/rhd_back.sv
// Back of the hazard detector: walks the access slots of queued instructions,
// checks and updates the per-register records and drives the hazard channel.
// Depends on rhd_pkg, rhd_if and rhd_ram.
module rhd_back
    import rhd_pkg::*;
#(
    parameter int NUM_REGS   = NUM_REGS_DEFAULT,
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT,
    parameter int REG_W      = 5,
    parameter int ENTRY_W    = INDEX_BITS + SLOT_COUNT + SLOT_COUNT * REG_W
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  logic [ENTRY_W-1:0] q_data,
    output logic               q_pop,
    rhd_dep_if.source          hazard
);

    typedef struct packed {
        logic [INDEX_BITS-1:0]                index;
        logic [SLOT_COUNT-1:0]                present;
        logic [SLOT_COUNT-1:0][REG_W-1:0]     regs;
    } entry_t;

    typedef struct packed {
        logic                  was_write;
        logic [INDEX_BITS-1:0] index;
    } rec_t;

    typedef struct packed {
        logic                  valid;
        logic                  done;
        dep_kind_t             kind;
        logic [REG_W-1:0]      regnum;
        logic [INDEX_BITS-1:0] earlier;
        logic [INDEX_BITS-1:0] later;
    } hold_t;

    entry_t                head;
    logic                  adv;
    logic [SLOT_COUNT-1:0] eff_mask;
    logic [SLOT_COUNT-1:0] pick_mask;
    logic [1:0]            pick_slot;
    logic                  pick_last;
    logic                  a_fire;

    // Slot walker state.
    logic                  started_reg, started_next;
    logic [SLOT_COUNT-1:0] rem_reg, rem_next;

    // Check stage registers.
    logic                  b_valid_reg;
    logic [REG_W-1:0]      b_regnum_reg;
    logic                  b_write_reg;
    logic [INDEX_BITS-1:0] b_index_reg;
    logic                  b_last_reg;

    // Record of the access checked at the last step, for the read-during-write case.
    logic                  fwd_valid_reg;
    logic [REG_W-1:0]      fwd_regnum_reg;
    rec_t                  fwd_rec_reg;

    logic [NUM_REGS-1:0]   touched_reg;
    rec_t                  ram_rdata;
    rec_t                  cur_rec;
    rec_t                  new_rec;
    logic                  emit;
    dep_kind_t             kind;

    hold_t                 hold_reg, hold_next;
    logic                  push;
    logic                  push_last;

    logic                  out_valid_reg;
    dep_kind_t             out_kind_reg;
    logic [REG_W-1:0]      out_regnum_reg;
    logic [INDEX_BITS-1:0] out_earlier_reg;
    logic [INDEX_BITS-1:0] out_later_reg;
    logic                  out_last_reg;

    // The whole back moves one step whenever the output register can take a beat.
    assign adv  = !out_valid_reg || hazard.ready;
    assign head = entry_t'(q_data);

    // Pick the next slot still to be carried out for the head instruction.
    always_comb
    begin
        eff_mask  = started_reg ? rem_reg : head.present;
        pick_mask = '0;
        pick_slot = 2'(SLOT_DEST);
        if (eff_mask[SLOT_SRC_A])
        begin
            pick_slot = 2'(SLOT_SRC_A);
        end
        else if (eff_mask[SLOT_SRC_B])
        begin
            pick_slot = 2'(SLOT_SRC_B);
        end
        pick_mask[pick_slot] = 1'b1;
        pick_last = ((eff_mask & ~pick_mask) == '0);
        a_fire    = adv && q_valid;
        q_pop     = a_fire && pick_last;

        started_next = started_reg;
        rem_next     = rem_reg;
        if (a_fire)
        begin
            started_next = !pick_last;
            rem_next     = eff_mask & ~pick_mask;
        end
    end

    // Per-register records; the read is issued from the pick, used one step later.
    rhd_ram #(
        .WIDTH ($bits(rec_t)),
        .DEPTH (NUM_REGS)
    ) u_rec_ram (
        .clk   (clk),
        .we    (adv && b_valid_reg),
        .waddr ($clog2(NUM_REGS)'(b_regnum_reg)),
        .wdata (new_rec),
        .rd_en (adv),
        .raddr ($clog2(NUM_REGS)'(head.regs[pick_slot])),
        .rdata (ram_rdata)
    );

    // Check the access against the register's record.
    always_comb
    begin
        cur_rec = ram_rdata;
        if (fwd_valid_reg && (fwd_regnum_reg == b_regnum_reg))
        begin
            cur_rec = fwd_rec_reg;
        end
        emit = b_valid_reg && touched_reg[b_regnum_reg]
               && (b_write_reg || cur_rec.was_write);
        if (!b_write_reg)
        begin
            kind = DEP_RAW;
        end
        else if (cur_rec.was_write)
        begin
            kind = DEP_WAW;
        end
        else
        begin
            kind = DEP_WAR;
        end
        new_rec.was_write = b_write_reg;
        new_rec.index     = b_index_reg;
    end

    // One hazard is held back until it is known whether it ends its instruction's run.
    always_comb
    begin
        push      = adv && hold_reg.valid
                    && (hold_reg.done || (b_valid_reg && (emit || b_last_reg)));
        push_last = hold_reg.done || (b_valid_reg && !emit && b_last_reg);
        hold_next = hold_reg;
        if (adv && emit)
        begin
            hold_next.valid   = 1'b1;
            hold_next.done    = b_last_reg;
            hold_next.kind    = kind;
            hold_next.regnum  = b_regnum_reg;
            hold_next.earlier = cur_rec.index;
            hold_next.later   = b_index_reg;
        end
        else if (push)
        begin
            hold_next.valid = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg    <= 1'b0;
            rem_reg        <= '0;
            b_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            touched_reg    <= '0;
            hold_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            started_reg    <= started_next;
            rem_reg        <= rem_next;
            hold_reg       <= hold_next;
            if (adv)
            begin
                b_valid_reg   <= a_fire;
                fwd_valid_reg <= b_valid_reg;
                if (b_valid_reg)
                begin
                    touched_reg[b_regnum_reg] <= 1'b1;
                end
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (hazard.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_regnum_reg   <= head.regs[pick_slot];
            b_write_reg    <= (pick_slot == 2'(SLOT_DEST));
            b_index_reg    <= head.index;
            b_last_reg     <= pick_last;
            fwd_regnum_reg <= b_regnum_reg;
            fwd_rec_reg    <= new_rec;
        end
        if (push)
        begin
            out_kind_reg    <= hold_reg.kind;
            out_regnum_reg  <= hold_reg.regnum;
            out_earlier_reg <= hold_reg.earlier;
            out_later_reg   <= hold_reg.later;
            out_last_reg    <= push_last;
        end
    end

    // Output channel.
    always_comb
    begin
        hazard.valid         = out_valid_reg;
        hazard.dep_kind      = out_kind_reg;
        hazard.dep_register  = DEP_REG_W'(out_regnum_reg);
        hazard.earlier_index = OUT_INDEX_W'(out_earlier_reg);
        hazard.later_index   = OUT_INDEX_W'(out_later_reg);
        hazard.last_of_run   = out_last_reg;
    end

endmodule

>>> src/register_hazard_detector.sv
// Channel   Dir  Beat contents
// instr     in   inst_type, src_a, src_b_or_dest, dest_reg (one decoded instruction)
// hazard    out  dep_kind, dep_register, earlier_index, later_index, last_of_run
//
// The back end carries out the present register accesses of an instruction one at a time,
// in slot order, as set by the record RAM's single read and write port.
// Instructions without accesses skip the back end; accepted every cycle unless q_full.
// Reset clears the access marks and the instruction counter at once; no clearing pass.
// A stalled hazard channel holds the back end; the queue then fills and instr stalls.
// Top level of the register hazard detector; depends on rhd_pkg, rhd_if and submodules.
module register_hazard_detector
    import rhd_pkg::*;
#(
    parameter int NUM_REGS   = NUM_REGS_DEFAULT,
    parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    rhd_inst_if.sink  instr,
    rhd_dep_if.source hazard
);

    localparam int REG_W   = $clog2(NUM_REGS);
    localparam int ENTRY_W = INDEX_BITS + SLOT_COUNT + SLOT_COUNT * REG_W;

    logic               q_push;
    logic [ENTRY_W-1:0] q_push_data;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_head;

    // Accept and decode.
    rhd_front #(
        .NUM_REGS   (NUM_REGS),
        .INDEX_BITS (INDEX_BITS),
        .REG_W      (REG_W),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr),
        .q_push (q_push),
        .q_data (q_push_data),
        .q_full (q_full)
    );

    // Decoupling queue.
    rhd_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_head)
    );

    // Check, update and report.
    rhd_back #(
        .NUM_REGS   (NUM_REGS),
        .INDEX_BITS (INDEX_BITS),
        .REG_W      (REG_W),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_data  (q_head),
        .q_pop   (q_pop),
        .hazard  (hazard)
    );

endmodule
